/* hdl/segx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection test package
// Shared widths, payload structs and decision codes for the segment
// intersection test block.
// ----------------------------------------------------------------------------
package segx_pkg;

  // Coordinate, difference, product and cross product widths. A difference
  // of two coordinates needs one more bit, a product of two differences
  // twice that, and the difference of two products one more bit again.
  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;

  // Which rule decided the answer.
  typedef enum logic [2:0] {
    DEC_NONE    = 3'd0,
    DEC_CROSS   = 3'd1,
    DEC_B_START = 3'd2,
    DEC_B_END   = 3'd3,
    DEC_A_START = 3'd4,
    DEC_A_END   = 3'd5
  } decide_t;

  // One pair of segments, signed fixed-point coordinates.
  typedef struct packed {
    logic signed [COORD_W-1:0] a_start_x;
    logic signed [COORD_W-1:0] a_start_y;
    logic signed [COORD_W-1:0] a_end_x;
    logic signed [COORD_W-1:0] a_end_y;
    logic signed [COORD_W-1:0] b_start_x;
    logic signed [COORD_W-1:0] b_start_y;
    logic signed [COORD_W-1:0] b_end_x;
    logic signed [COORD_W-1:0] b_end_y;
  } seg_in_t;

  // One test result.
  typedef struct packed {
    logic    intersects;
    decide_t decided_by;
  } seg_out_t;

  // Sign of an orientation cross product.
  typedef struct packed {
    logic neg;
    logic zero;
  } orient_t;

endpackage

/* hdl/segment_intersection_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection test
// Reports whether two line segments intersect, from exact orientation signs
// of cross products, with strict collinear-touch checks as a fallback.
// ----------------------------------------------------------------------------
// A transaction accepted on start passes the input, product and result registers
// in that order; its result and done both come from the result register.
// Throughput: one transaction per cycle; busy stays low, since the three
// register stages (input, products, result) each pass one item per cycle.
// The 33 x 33 bit products set the length of the middle stage.
// Reset clears the stage valid bits; the receiver cannot stall the block.
module segment_intersection_test
  import segx_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  seg_in_t  operands,
  output logic     done,
  output seg_out_t result
);

  // Sign-extended difference a - b.
  function automatic logic signed [DIFF_W-1:0] diff(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [DIFF_W-1:0] ea;
    logic signed [DIFF_W-1:0] eb;
    ea = DIFF_W'(a);
    eb = DIFF_W'(b);
    return ea - eb;
  endfunction

  // Value q lies strictly between p and r.
  function automatic logic between(
    input logic signed [COORD_W-1:0] q,
    input logic signed [COORD_W-1:0] p,
    input logic signed [COORD_W-1:0] r
  );
    return ((q > p) && (q < r)) || ((q < p) && (q > r));
  endfunction

  // Sign of the difference of two products.
  function automatic orient_t orient(
    input logic signed [PROD_W-1:0] pl,
    input logic signed [PROD_W-1:0] pr
  );
    logic signed [CROSS_W-1:0] cross_val;
    orient_t o;
    cross_val = CROSS_W'(pl) - CROSS_W'(pr);
    o.neg     = cross_val[CROSS_W-1];
    o.zero    = (cross_val == '0);
    return o;
  endfunction

  // The block takes a transaction every cycle.
  assign busy = 1'b0;

  // ---------------------------------------------------------------- stage 0
  seg_in_t in_q;
  logic    valid0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
    end else begin
      valid0 <= start && !busy;
    end
    if (start && !busy) begin
      in_q <= operands;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Coordinate differences for the four orientation tests.
  logic signed [DIFF_W-1:0] d_a_dx, d_a_dy, d_b_dx, d_b_dy;
  logic signed [DIFF_W-1:0] d_b0x, d_b0y, d_b1x, d_b1y;
  logic signed [DIFF_W-1:0] d_a0x, d_a0y, d_a1x, d_a1y;

  always_comb begin
    d_a_dx = diff(in_q.a_end_x,   in_q.a_start_x);
    d_a_dy = diff(in_q.a_end_y,   in_q.a_start_y);
    d_b_dx = diff(in_q.b_end_x,   in_q.b_start_x);
    d_b_dy = diff(in_q.b_end_y,   in_q.b_start_y);
    d_b0x  = diff(in_q.b_start_x, in_q.a_end_x);
    d_b0y  = diff(in_q.b_start_y, in_q.a_end_y);
    d_b1x  = diff(in_q.b_end_x,   in_q.a_end_x);
    d_b1y  = diff(in_q.b_end_y,   in_q.a_end_y);
    d_a0x  = diff(in_q.a_start_x, in_q.b_end_x);
    d_a0y  = diff(in_q.a_start_y, in_q.b_end_y);
    d_a1x  = diff(in_q.a_end_x,   in_q.b_end_x);
    d_a1y  = diff(in_q.a_end_y,   in_q.b_end_y);
  end

  // Products, left and right term of each cross product.
  logic signed [PROD_W-1:0] p1l, p1r, p2l, p2r, p3l, p3r, p4l, p4r;
  logic in_b0, in_b1, in_a0, in_a1;
  logic valid1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= valid0;
    end
    p1l   <= d_a_dy * d_b0x;
    p1r   <= d_a_dx * d_b0y;
    p2l   <= d_a_dy * d_b1x;
    p2r   <= d_a_dx * d_b1y;
    p3l   <= d_b_dy * d_a0x;
    p3r   <= d_b_dx * d_a0y;
    p4l   <= d_b_dy * d_a1x;
    p4r   <= d_b_dx * d_a1y;
    // Strict bounding-box tests of each end point against the other segment.
    in_b0 <= between(in_q.b_start_x, in_q.a_start_x, in_q.a_end_x) &&
             between(in_q.b_start_y, in_q.a_start_y, in_q.a_end_y);
    in_b1 <= between(in_q.b_end_x, in_q.a_start_x, in_q.a_end_x) &&
             between(in_q.b_end_y, in_q.a_start_y, in_q.a_end_y);
    in_a0 <= between(in_q.a_start_x, in_q.b_start_x, in_q.b_end_x) &&
             between(in_q.a_start_y, in_q.b_start_y, in_q.b_end_y);
    in_a1 <= between(in_q.a_end_x, in_q.b_start_x, in_q.b_end_x) &&
             between(in_q.a_end_y, in_q.b_start_y, in_q.b_end_y);
  end

  // ---------------------------------------------------------------- stage 2
  orient_t  o1, o2, o3, o4;
  seg_out_t result_next;

  always_comb begin
    o1 = orient(p1l, p1r);
    o2 = orient(p2l, p2r);
    o3 = orient(p3l, p3r);
    o4 = orient(p4l, p4r);
  end

  // A proper crossing first, then the collinear touches in fixed order.
  always_comb begin
    if ((o1 != o2) && (o3 != o4)) begin
      result_next.decided_by = DEC_CROSS;
    end else if (o1.zero && in_b0) begin
      result_next.decided_by = DEC_B_START;
    end else if (o2.zero && in_b1) begin
      result_next.decided_by = DEC_B_END;
    end else if (o3.zero && in_a0) begin
      result_next.decided_by = DEC_A_START;
    end else if (o4.zero && in_a1) begin
      result_next.decided_by = DEC_A_END;
    end else begin
      result_next.decided_by = DEC_NONE;
    end
    result_next.intersects = (result_next.decided_by != DEC_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid1;
    end
    result <= result_next;
  end

endmodule

/* tb/segment_intersection_test_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection test bench
// Drives pairs of segments into the intersection test block: a directed set
// first (full-scale corners, each decision rule, end-point touches and
// degenerate segments), then random pairs drawn from wide, narrow, collinear
// and shared-end-point mixes. Every result is checked field by field against
// an exact cross-product predictor.
// ----------------------------------------------------------------------------
module segment_intersection_test_test;
  import segx_pkg::*;

  localparam int ONE       = 1 << 16;
  localparam int N_RANDOM  = 1250;
  localparam int TURN_W    = CROSS_W + 1;

  logic     clk      = 1'b0;
  logic     rst      = 1'b1;
  logic     start    = 1'b0;
  seg_in_t  operands = '0;
  logic     busy;
  logic     done;
  seg_out_t result;

  seg_in_t  pending_pairs[$];
  seg_out_t expected_verdicts[$];
  int       idle_left  = 0;
  int       burst_left = 0;
  int       mismatches = 0;
  int       pairs_checked = 0;
  int       code_seen[0:7];

  segment_intersection_test DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .operands(operands),
    .done    (done),
    .result  (result)
  );

  // 100 MHz clock.
  always #5 clk = ~clk;

  // Sign of the turn from p through q to r, from an exact cross product.
  function automatic int turn_sign(input logic signed [COORD_W-1:0] px, py, qx, qy, rx, ry);
    logic signed [TURN_W-1:0] epx, epy, eqx, eqy, erx, ery, cprod;
    epx = px;
    epy = py;
    eqx = qx;
    eqy = qy;
    erx = rx;
    ery = ry;
    cprod = (eqy - epy) * (erx - eqx) - (eqx - epx) * (ery - eqy);
    if (cprod < 0) return -1;
    if (cprod != 0) return 1;
    return 0;
  endfunction

  // True when q lies strictly inside the box spanned by p and r on both axes.
  function automatic bit strictly_within(input logic signed [COORD_W-1:0] px, py, qx, qy, rx, ry);
    logic signed [COORD_W-1:0] xlo, xhi, ylo, yhi;
    xlo = (px < rx) ? px : rx;
    xhi = (px > rx) ? px : rx;
    ylo = (py < ry) ? py : ry;
    yhi = (py > ry) ? py : ry;
    return (qx > xlo) && (qx < xhi) && (qy > ylo) && (qy < yhi);
  endfunction

  // Expected verdict for one pair of segments.
  function automatic seg_out_t predict_crossing(input seg_in_t s);
    logic signed [COORD_W-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    int       side_bs, side_be, side_as, side_ae;
    decide_t  code;
    seg_out_t verdict;
    ax0 = s.a_start_x;
    ay0 = s.a_start_y;
    ax1 = s.a_end_x;
    ay1 = s.a_end_y;
    bx0 = s.b_start_x;
    by0 = s.b_start_y;
    bx1 = s.b_end_x;
    by1 = s.b_end_y;
    side_bs = turn_sign(ax0, ay0, ax1, ay1, bx0, by0);
    side_be = turn_sign(ax0, ay0, ax1, ay1, bx1, by1);
    side_as = turn_sign(bx0, by0, bx1, by1, ax0, ay0);
    side_ae = turn_sign(bx0, by0, bx1, by1, ax1, ay1);
    code = DEC_NONE;
    if (side_bs != side_be && side_as != side_ae) begin
      code = DEC_CROSS;
    end else if (side_bs == 0 && strictly_within(ax0, ay0, bx0, by0, ax1, ay1)) begin
      code = DEC_B_START;
    end else if (side_be == 0 && strictly_within(ax0, ay0, bx1, by1, ax1, ay1)) begin
      code = DEC_B_END;
    end else if (side_as == 0 && strictly_within(bx0, by0, ax0, ay0, bx1, by1)) begin
      code = DEC_A_START;
    end else if (side_ae == 0 && strictly_within(bx0, by0, ax1, ay1, bx1, by1)) begin
      code = DEC_A_END;
    end
    verdict.intersects = (code != DEC_NONE);
    verdict.decided_by = code;
    return verdict;
  endfunction

  function automatic seg_in_t make_pair(input int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
    seg_in_t s;
    s.a_start_x = ax0;
    s.a_start_y = ay0;
    s.a_end_x   = ax1;
    s.a_end_y   = ay1;
    s.b_start_x = bx0;
    s.b_start_y = by0;
    s.b_end_x   = bx1;
    s.b_end_y   = by1;
    return s;
  endfunction

  // Appends one pair to the stimulus queue.
  function automatic void enqueue_pair(input seg_in_t s);
    pending_pairs.insert(pending_pairs.size(), s);
  endfunction

  // Driver: presents one transaction at a time, with random idle gaps and
  // occasional back-to-back bursts.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_left = 0;
    end else if (!(start && busy)) begin
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_pairs.size() != 0) begin
        operands <= pending_pairs[0];
        pending_pairs.delete(0);
        start    <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
          idle_left = 0;
        end else if ($urandom_range(0, 7) == 0) begin
          burst_left = $urandom_range(10, 40);
          idle_left  = 0;
        end else begin
          idle_left = $urandom_range(0, 17);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each result against the oldest prediction, then records
  // the prediction for a transaction accepted at this edge.
  always @(posedge clk) begin
    seg_out_t want;
    if (!rst) begin
      if (done) begin
        if (expected_verdicts.size() == 0) begin
          $error("result with no transaction outstanding: intersects=%0d decided_by=%0d",
                 result.intersects, result.decided_by);
          mismatches++;
        end else begin
          want = expected_verdicts[0];
          expected_verdicts.delete(0);
          pairs_checked++;
          code_seen[int'(want.decided_by)]++;
          if (result.intersects !== want.intersects) begin
            $error("intersects: expected %0d, got %0d", want.intersects, result.intersects);
            mismatches++;
          end
          if (result.decided_by !== want.decided_by) begin
            $error("decided_by: expected %0d, got %0d", want.decided_by, result.decided_by);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        expected_verdicts.insert(expected_verdicts.size(), predict_crossing(operands));
      end
    end
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus, reset and end of run.
  initial begin
    int kind, bx, by, dx, dy, span;
    int t[4];
    seg_in_t s;
    for (int i = 0; i < 8; i++) code_seen[i] = 0;

    // Directed pairs.
    enqueue_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    enqueue_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                           32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    enqueue_pair(make_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                           32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    enqueue_pair(make_pair(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                           32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    // Collinear overlaps, one for each touch rule.
    enqueue_pair(make_pair(0, 0, 100*ONE, 100*ONE, 50*ONE, 50*ONE, 200*ONE, 200*ONE));
    enqueue_pair(make_pair(0, 0, 100*ONE, 100*ONE, 200*ONE, 200*ONE, 50*ONE, 50*ONE));
    enqueue_pair(make_pair(50*ONE, 50*ONE, 60*ONE, 60*ONE, 0, 0, 100*ONE, 100*ONE));
    enqueue_pair(make_pair(100*ONE, 100*ONE, 50*ONE, 50*ONE, 0, 0, 100*ONE, 100*ONE));
    // Full-scale collinear overlap.
    enqueue_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                           0, 0, 32'h7fff_ffff, 32'h7fff_ffff));
    // Collinear on an axis-parallel line never counts as inside.
    enqueue_pair(make_pair(0, 0, 100*ONE, 0, 50*ONE, 0, 200*ONE, 0));
    enqueue_pair(make_pair(0, 0, 0, 100*ONE, 0, 50*ONE, 0, 200*ONE));
    // Shared end point, not collinear.
    enqueue_pair(make_pair(0, 0, 100*ONE, 100*ONE, 100*ONE, 100*ONE, 200*ONE, 0));
    // Collinear, touching only at end points.
    enqueue_pair(make_pair(0, 0, 100*ONE, 100*ONE, 100*ONE, 100*ONE, 200*ONE, 200*ONE));
    // Disjoint pairs: one parallel, one not.
    enqueue_pair(make_pair(0, 0, 100*ONE, 100*ONE, 0, ONE, 100*ONE, 101*ONE));
    enqueue_pair(make_pair(0, 0, ONE, ONE, 10*ONE, 0, 20*ONE, -5*ONE));
    // Degenerate segments: a point inside the other segment, two equal points.
    enqueue_pair(make_pair(50*ONE, 50*ONE, 50*ONE, 50*ONE, 0, 0, 100*ONE, 100*ONE));
    enqueue_pair(make_pair(0, 0, 100*ONE, 100*ONE, 50*ONE, 50*ONE, 50*ONE, 50*ONE));
    enqueue_pair(make_pair(7, -7, 7, -7, 7, -7, 7, -7));
    // Proper crossing with T-junction touch and small fractional values.
    enqueue_pair(make_pair(-1, -1, 1, 1, -1, 1, 1, -1));
    enqueue_pair(make_pair(0, 0, 10*ONE, 0, 5*ONE, 0, 5*ONE, 5*ONE));

    // Random pairs.
    repeat (N_RANDOM) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        // Full-width random coordinates.
        s = {$urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom(), $urandom()};
      end else if (kind < 55) begin
        // Coarse grid, so touches and collinear cases are frequent.
        s = make_pair((int'($urandom_range(0, 16)) - 8) * ONE,
                      (int'($urandom_range(0, 16)) - 8) * ONE,
                      (int'($urandom_range(0, 16)) - 8) * ONE,
                      (int'($urandom_range(0, 16)) - 8) * ONE,
                      (int'($urandom_range(0, 16)) - 8) * ONE,
                      (int'($urandom_range(0, 16)) - 8) * ONE,
                      (int'($urandom_range(0, 16)) - 8) * ONE,
                      (int'($urandom_range(0, 16)) - 8) * ONE);
      end else if (kind < 88) begin
        // Four points along one line at random scale.
        span = 1 << $urandom_range(0, 24);
        bx = int'($urandom_range(0, 1 << 28)) - (1 << 27);
        by = int'($urandom_range(0, 1 << 28)) - (1 << 27);
        dx = int'($urandom_range(0, 2 * span)) - span;
        dy = int'($urandom_range(0, 2 * span)) - span;
        foreach (t[i]) t[i] = int'($urandom_range(0, 8)) - 4;
        s = make_pair(bx + t[0]*dx, by + t[0]*dy, bx + t[1]*dx, by + t[1]*dy,
                      bx + t[2]*dx, by + t[2]*dy, bx + t[3]*dx, by + t[3]*dy);
      end else begin
        // Shared end points and degenerate segments on wide coordinates.
        s = {$urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom(), $urandom()};
        case ($urandom_range(0, 3))
          0: begin
            s.b_start_x = s.a_end_x;
            s.b_start_y = s.a_end_y;
          end
          1: begin
            s.b_end_x = s.a_start_x;
            s.b_end_y = s.a_start_y;
          end
          2: begin
            s.a_end_x = s.a_start_x;
            s.a_end_y = s.a_start_y;
          end
          default: begin
            s.b_end_x = s.b_start_x;
            s.b_end_y = s.b_start_y;
          end
        endcase
      end
      enqueue_pair(s);
    end

    // Reset, then let the driver run.
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Drain: all stimulus taken, all results back, then a few quiet cycles.
    do @(negedge clk); while (pending_pairs.size() != 0 || start);
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Checked %0d segment pairs: %0d proper crossings, %0d collinear touches, %0d misses.",
             pairs_checked, code_seen[1],
             code_seen[2] + code_seen[3] + code_seen[4] + code_seen[5], code_seen[0]);
    $display("Touch rules hit: B start %0d, B end %0d, A start %0d, A end %0d.",
             code_seen[2], code_seen[3], code_seen[4], code_seen[5]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
